// File: sv/mi3_pkg.sv
// Package for the 3x3 matrix inverse unit.
// Holds the fixed widths, the pipeline word types and the saturation helper.
// No dependencies.
package mi3_pkg;

   localparam int ELEM_W  = 32;               // matrix and result element width
   localparam int LANES   = 9;                // elements per matrix
   localparam int CROSS_W = 64;               // cross-product entry, exact
   localparam int DET_W   = 98;               // signed determinant, exact
   localparam int DMAG_W  = 97;               // determinant magnitude
   localparam int QUO_W   = 33;               // quotient bits developed
   localparam int DIV_W   = DMAG_W + QUO_W;   // divider remainder width

   localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic [ELEM_W-1:0] elem_type;

   // matrix word entering the pipe
   typedef struct packed {
      logic                   valid;
      elem_type [LANES-1:0]   a;        // a[row*3+col]
   } mat_type;

   // cross products r_i (row i of the adjugate) plus column 2
   typedef struct packed {
      logic                            valid;
      logic [LANES-1:0][CROSS_W-1:0]   r;     // r[row*3+col], signed
      elem_type [2:0]                  c2;    // column 2 of the input
   } cross_type;

   // one lane group inside the divider
   typedef struct packed {
      logic                          valid;
      logic                          sing;
      logic                          dneg;
      logic [DMAG_W-1:0]             dmag;
      elem_type                      det_value;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0]              ovf;
      logic [LANES-1:0][DIV_W-1:0]   rem;
      logic [LANES-1:0][QUO_W-1:0]   quo;
   } div_type;

   // result word
   typedef struct packed {
      logic                   valid;
      logic                   sing;
      elem_type               det_value;
      elem_type [LANES-1:0]   inv;
   } rsp_type;

   // signed 32-bit value from sign and magnitude, saturated
   function automatic elem_type sat32(input logic neg, input logic [DMAG_W:0] mag);
      elem_type res;
      if (!neg) begin
         res = (mag > (DMAG_W+1)'(SAT_POS)) ? SAT_POS : mag[ELEM_W-1:0];
      end else begin
         res = (mag > (DMAG_W+1)'(SAT_NEG)) ? SAT_NEG : (~mag[ELEM_W-1:0] + 32'd1);
      end
      return res;
   endfunction

endpackage

// File: sv/matrix_inverse_3x3_unit.sv
// 3x3 matrix inverse and determinant, signed fixed point, fully pipelined.
// The pipe has 2 cross-product stages, 5 determinant stages,
// 33 divider stages (one quotient bit each) and the output register.
// Throughput one matrix per cycle; a stalled output holds the whole pipe.
// Synchronous reset clears the valid bits only; no other state is kept.
module matrix_inverse_3x3_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_r0c0, a_r0c1, a_r0c2, a_r1c0 .. a_r2c2, 32 bits each from bit 0
   input  logic [287:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // inv_r0c0 .. inv_r2c2, det_value, 32 bits each from bit 0
   output logic [319:0]  rsp_tdata,
   // singular
   output logic          rsp_tuser
);

   logic                  en;
   mi3_pkg::mat_type      m;
   mi3_pkg::cross_type    x;
   mi3_pkg::div_type      dv [mi3_pkg::QUO_W+1];
   mi3_pkg::rsp_type      o;

   // whole pipe moves when the output word is empty or taken
   assign en         = !o.valid || rsp_tready;
   assign req_tready = en;
   assign m.valid    = req_tvalid;
   assign m.a        = req_tdata;

   mi3_cross u_cross (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .m     (m),
      .x     (x)
   );

   mi3_det #(
      .FRAC_BITS (FRAC_BITS)
   ) u_det (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .x     (x),
      .d     (dv[0])
   );

   // quotient bits from the top down
   for (genvar gs = 0; gs < mi3_pkg::QUO_W; gs++) begin : g_div
      mi3_div_stage #(
         .BIT (mi3_pkg::QUO_W - 1 - gs)
      ) u_stage (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (dv[gs]),
         .q     (dv[gs+1])
      );
   end

   mi3_out u_out (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .d     (dv[mi3_pkg::QUO_W]),
      .o     (o)
   );

   assign rsp_tvalid = o.valid;
   assign rsp_tdata  = {o.det_value, o.inv};
   assign rsp_tuser  = o.sing;

   // a singular result carries all-zero data
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("singular word with nonzero data");

   // input is refused only behind a stalled output word
   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused without output stall");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

// File: sv/mi3_cross.sv
// Cross-product section: two stages, 18 products then 9 differences.
// Depends on mi3_pkg.
module mi3_cross (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  mi3_pkg::mat_type    m,
   output mi3_pkg::cross_type  x
);

   logic signed [mi3_pkg::CROSS_W-1:0] prod_in [mi3_pkg::LANES][2];
   logic signed [mi3_pkg::CROSS_W-1:0] prod_ff [mi3_pkg::LANES][2];
   logic                               valid1_ff;
   mi3_pkg::elem_type [2:0]            c2_ff;
   mi3_pkg::cross_type                 x_in;
   mi3_pkg::cross_type                 x_ff;

   // r_i = c(i+1) x c(i+2); column c element e is a[e*3+c]
   for (genvar gi = 0; gi < 3; gi++) begin : g_row
      for (genvar gk = 0; gk < 3; gk++) begin : g_col
         localparam int UC = (gi + 1) % 3;
         localparam int VC = (gi + 2) % 3;
         localparam int E1 = (gk + 1) % 3;
         localparam int E2 = (gk + 2) % 3;
         assign prod_in[gi*3+gk][0] = $signed(m.a[E1*3+UC]) * $signed(m.a[E2*3+VC]);
         assign prod_in[gi*3+gk][1] = $signed(m.a[E2*3+UC]) * $signed(m.a[E1*3+VC]);
      end
   end

   // stage 1: products
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= m.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         c2_ff   <= {m.a[8], m.a[5], m.a[2]};
      end
   end

   // stage 2: differences, exact in 64 bits
   always_comb begin
      x_in.valid = valid1_ff;
      x_in.c2    = c2_ff;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         x_in.r[l] = prod_ff[l][0] - prod_ff[l][1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff.valid <= 1'b0;
      end else if (en) begin
         x_ff <= x_in;
      end
   end

   assign x = x_ff;

endmodule

// File: sv/mi3_det.sv
// Determinant section: five stages from cross products to divider entry.
// Depends on mi3_pkg.
module mi3_det #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  mi3_pkg::cross_type  x,
   output mi3_pkg::div_type    d
);

   localparam int SHIFT = 2 * FRAC_BITS;
   localparam logic [mi3_pkg::DMAG_W:0] HALF = (mi3_pkg::DMAG_W+1)'(1) << (SHIFT - 1);

   // stage 1: split r2 x c2 into 33x32 and 32x32 partial products
   logic signed [64:0]                  pl_in [3];
   logic signed [63:0]                  ph_in [3];
   logic signed [64:0]                  pl_ff [3];
   logic signed [63:0]                  ph_ff [3];
   logic [mi3_pkg::LANES-1:0][mi3_pkg::CROSS_W-1:0] r1_ff, r2_ff, r3_ff;
   logic                                v1_ff, v2_ff, v3_ff, v4_ff;

   for (genvar gi = 0; gi < 3; gi++) begin : g_part
      assign pl_in[gi] = $signed({1'b0, x.r[6+gi][31:0]}) * $signed(x.c2[gi]);
      assign ph_in[gi] = $signed(x.r[6+gi][63:32]) * $signed(x.c2[gi]);
   end

   // stage 2: whole products; stage 3: sum
   logic signed [mi3_pkg::DET_W-1:0] p_in [3];
   logic signed [mi3_pkg::DET_W-1:0] p_ff [3];
   logic signed [mi3_pkg::DET_W-1:0] det_in, det_ff;

   for (genvar gi = 0; gi < 3; gi++) begin : g_prod
      assign p_in[gi] = (mi3_pkg::DET_W'(ph_ff[gi]) <<< 32) + mi3_pkg::DET_W'(pl_ff[gi]);
   end
   assign det_in = p_ff[0] + p_ff[1] + p_ff[2];

   // stage 4: magnitudes and signs
   logic                                dneg_in, dneg_ff;
   logic                                sing_in, sing_ff;
   logic [mi3_pkg::DMAG_W-1:0]          dmag_in, dmag_ff;
   logic [mi3_pkg::LANES-1:0][63:0]     mag_in, mag_ff;
   logic [mi3_pkg::LANES-1:0]           neg_in, neg_ff;

   always_comb begin
      dneg_in = det_ff[mi3_pkg::DET_W-1];
      sing_in = (det_ff == '0);
      dmag_in = dneg_in ? mi3_pkg::DMAG_W'(-det_ff) : mi3_pkg::DMAG_W'(det_ff);
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         mag_in[l] = r3_ff[l][63] ? (64'd0 - r3_ff[l]) : r3_ff[l];
         neg_in[l] = r3_ff[l][63] ^ dneg_in;
      end
   end

   // stage 5: numerators, overflow test, rounded determinant
   mi3_pkg::div_type             d_in, d_ff;
   logic [mi3_pkg::DMAG_W:0]     rsum;
   logic [mi3_pkg::DIV_W-1:0]    num;
   logic [mi3_pkg::DIV_W-1:0]    dlim;

   always_comb begin
      rsum = ({1'b0, dmag_ff} + HALF) >> SHIFT;
      dlim = {dmag_ff, {mi3_pkg::QUO_W{1'b0}}};
      num  = '0;
      d_in.valid     = v4_ff;
      d_in.sing      = sing_ff;
      d_in.dneg      = dneg_ff;
      d_in.dmag      = dmag_ff;
      d_in.det_value = sing_ff ? '0 : mi3_pkg::sat32(dneg_ff, rsum);
      d_in.neg       = neg_ff;
      d_in.quo       = '0;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         num          = mi3_pkg::DIV_W'(mag_ff[l]) << SHIFT;
         d_in.rem[l]  = num;
         d_in.ovf[l]  = (num >= dlim);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= x.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         r1_ff   <= x.r;
         p_ff    <= p_in;
         r2_ff   <= r1_ff;
         det_ff  <= det_in;
         r3_ff   <= r2_ff;
         dneg_ff <= dneg_in;
         sing_ff <= sing_in;
         dmag_ff <= dmag_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else if (en) begin
         d_ff <= d_in;
      end
   end

   assign d = d_ff;

endmodule

// File: sv/mi3_div_stage.sv
// One restoring-division stage: develops quotient bit BIT on all nine lanes.
// Depends on mi3_pkg.
module mi3_div_stage #(
   parameter int BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  mi3_pkg::div_type  d,
   output mi3_pkg::div_type  q
);

   mi3_pkg::div_type           q_in, q_ff;
   logic [mi3_pkg::DIV_W-1:0]  sub;

   // trial subtract of dmag * 2^BIT
   always_comb begin
      q_in = d;
      sub  = mi3_pkg::DIV_W'(d.dmag) << BIT;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         if (d.rem[l] >= sub) begin
            q_in.rem[l]      = d.rem[l] - sub;
            q_in.quo[l][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// File: sv/mi3_out.sv
// Output stage: rounds each quotient, saturates, zeroes a singular result.
// Depends on mi3_pkg.
module mi3_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  mi3_pkg::div_type  d,
   output mi3_pkg::rsp_type  o
);

   mi3_pkg::rsp_type          o_in, o_ff;
   logic [mi3_pkg::DMAG_W:0]  qr;
   logic                      rnd;

   // round to nearest, ties away from zero, then saturate
   always_comb begin
      qr  = '0;
      rnd = 1'b0;
      o_in.valid     = d.valid;
      o_in.sing      = d.sing;
      o_in.det_value = d.det_value;
      for (int l = 0; l < mi3_pkg::LANES; l++) begin
         rnd = ({d.rem[l][mi3_pkg::DMAG_W-1:0], 1'b0} >= {1'b0, d.dmag});
         qr  = (mi3_pkg::DMAG_W+1)'(d.quo[l]) + (mi3_pkg::DMAG_W+1)'(rnd);
         if (d.sing) begin
            o_in.inv[l] = '0;
         end else if (d.ovf[l]) begin
            o_in.inv[l] = d.neg[l] ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
         end else begin
            o_in.inv[l] = mi3_pkg::sat32(d.neg[l], qr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_ff.valid <= 1'b0;
      end else if (en) begin
         o_ff <= o_in;
      end
   end

   assign o = o_ff;

endmodule

// File: dv/tb_matrix_inverse_3x3_unit.sv
// Testbench for matrix_inverse_3x3_unit: streams matrices in, checks determinant,
// inverse and singular flag against an exact wide-integer predictor.
// Depends on sv/mi3_pkg.sv and sv/matrix_inverse_3x3_unit.sv.
module tb_matrix_inverse_3x3_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam logic [31:0] ONE_Q = 32'h0001_0000;

   // expected result word
   typedef struct {
      logic [319:0] data;
      logic         sing;
   } inverse_word_type;

   class inverse_scoreboard;
      inverse_word_type pending[$];
      int               mismatches;
      int               checked;
      int               singular_seen;
      int               saturated_seen;

      function logic [31:0] saturate(bit neg, logic [127:0] mag);
         if (!neg) return (mag > 128'h7FFF_FFFF) ? mi3_pkg::SAT_POS : mag[31:0];
         return (mag > 128'h8000_0000) ? mi3_pkg::SAT_NEG : (~mag[31:0] + 32'd1);
      endfunction

      // exact determinant and rounded, saturated inverse
      function inverse_word_type invert_matrix(logic [287:0] m);
         logic signed [127:0] a[9];
         logic signed [127:0] r[9];
         logic signed [127:0] det, rv;
         logic [127:0]        dmag, num, q, rem;
         logic [31:0]         u[3], v[3];
         bit                  dneg;
         inverse_word_type    res;
         for (int k = 0; k < 9; k++) a[k] = $signed(m[32*k +: 32]);
         // row i of adjugate = column(i+1) x column(i+2)
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               u[k] = a[k*3 + (i+1)%3];
               v[k] = a[k*3 + (i+2)%3];
            end
            r[i*3+0] = $signed(u[1]) * $signed(v[2]) - $signed(u[2]) * $signed(v[1]);
            r[i*3+1] = $signed(u[2]) * $signed(v[0]) - $signed(u[0]) * $signed(v[2]);
            r[i*3+2] = $signed(u[0]) * $signed(v[1]) - $signed(u[1]) * $signed(v[0]);
         end
         det = 0;
         for (int k = 0; k < 3; k++) det += r[6+k] * a[k*3+2];
         dneg = det < 0;
         dmag = dneg ? -det : det;
         res.data = '0;
         res.sing = (dmag == 0);
         if (res.sing) return res;
         res.data[288 +: 32] = saturate(dneg, (dmag + (128'd1 << (2*FRAC-1))) >> (2*FRAC));
         for (int k = 0; k < 9; k++) begin
            rv  = r[k];
            num = (rv < 0 ? -rv : rv) << (2*FRAC);
            q   = num / dmag;
            rem = num % dmag;
            if ((rem << 1) >= dmag) q = q + 1;
            res.data[32*k +: 32] = saturate(((rv < 0) != dneg) && num != 0, q);
         end
         return res;
      endfunction

      function void note_matrix(logic [287:0] m);
         pending.push_back(invert_matrix(m));
      endfunction

      function void check_result(logic [319:0] data, logic sing);
         inverse_word_type exp_w;
         bit               bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result word %h", data);
            return;
         end
         exp_w = pending.pop_front();
         checked++;
         if (exp_w.sing) singular_seen++;
         for (int k = 0; k < 10; k++)
            if (exp_w.data[32*k +: 32] inside {mi3_pkg::SAT_POS, mi3_pkg::SAT_NEG})
               saturated_seen++;
         bad = (sing !== exp_w.sing);
         for (int k = 0; k < 10; k++)
            if (data[32*k +: 32] !== exp_w.data[32*k +: 32]) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d mismatch, singular exp %b got %b",
                        checked, exp_w.sing, sing);
               for (int k = 0; k < 10; k++)
                  if (data[32*k +: 32] !== exp_w.data[32*k +: 32])
                     $display("  field %0d (9 = det): exp %h got %h",
                              k, exp_w.data[32*k +: 32], data[32*k +: 32]);
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [319:0] rsp_tdata;
   logic         rsp_tuser;

   inverse_scoreboard sb;
   int sender_idle_pct;
   int receiver_idle_pct;
   int sent;

   matrix_inverse_3x3_unit #(.FRAC_BITS(FRAC)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // monitors on both channels
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_matrix(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // drive one matrix word and wait for acceptance, then maybe idle
   task automatic send_matrix(logic [287:0] m);
      req_tvalid <= 1'b1;
      req_tdata  <= m;
      do @(posedge clock); while (!req_tready);
      sent++;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {9{$urandom()}};
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [287:0] pack9(logic [31:0] e0, e1, e2, e3, e4, e5, e6, e7, e8);
      return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
   endfunction

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(3) == 0 ? mi3_pkg::SAT_POS : mi3_pkg::SAT_NEG;
         2: return $urandom_range(7) - 4;
         default: return 32'($signed($urandom_range(20 * ONE_Q)) - 10 * ONE_Q);
      endcase
   endfunction

   function automatic logic [287:0] random_matrix();
      logic [287:0] m;
      for (int k = 0; k < 9; k++) m[32*k +: 32] = rand_elem();
      // some matrices made singular by repeating a row or zeroing a column
      case ($urandom_range(9))
         0: m[192 +: 96] = m[0 +: 96];
         1: for (int i = 0; i < 3; i++) m[32*(i*3+1) +: 32] = 32'd0;
         default: ;
      endcase
      return m;
   endfunction

   task automatic directed_matrices();
      send_matrix(pack9(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
      send_matrix(pack9(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
      send_matrix('0);
      send_matrix({9{mi3_pkg::SAT_POS}});
      send_matrix({9{mi3_pkg::SAT_NEG}});
      send_matrix(pack9(mi3_pkg::SAT_POS, 0, 0, 0, mi3_pkg::SAT_POS, 0, 0, 0,
                        mi3_pkg::SAT_POS));
      send_matrix(pack9(mi3_pkg::SAT_NEG, 0, 0, 0, mi3_pkg::SAT_NEG, 0, 0, 0,
                        mi3_pkg::SAT_NEG));
      send_matrix(pack9(mi3_pkg::SAT_NEG, mi3_pkg::SAT_POS, 0, 0, mi3_pkg::SAT_NEG,
                        mi3_pkg::SAT_POS, mi3_pkg::SAT_POS, 0, mi3_pkg::SAT_NEG));
      // tiny determinant: det rounds to zero, inverse saturates
      send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1));
      send_matrix(pack9(2 * ONE_Q, ONE_Q, 0, ONE_Q, 3 * ONE_Q, ONE_Q, 0, ONE_Q, 4 * ONE_Q));
      send_matrix(pack9(0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0));
      // rounding: det 27, inverse thirds
      send_matrix(pack9(3 * ONE_Q, 0, 0, 0, 3 * ONE_Q, 0, 0, 0, 3 * ONE_Q));
      send_matrix(pack9(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q, 6 * ONE_Q,
                        7 * ONE_Q, 8 * ONE_Q, 9 * ONE_Q));
      send_matrix({9{32'hFFFF_FFFF}});
      send_matrix(pack9(32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'hAAAA_AAAA, 0, 32'h5555_5555));
   endtask

   initial begin
      sb = new();
      sent = 0;
      sender_idle_pct   = 15;
      receiver_idle_pct = 56;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_matrices();
      repeat (120) send_matrix(random_matrix());
      // hold the sender until everything is back
      drain();
      sender_idle_pct   = 56;
      receiver_idle_pct = 15;
      repeat (130) send_matrix(random_matrix());
      drain();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      repeat (135) send_matrix(random_matrix());
      drain();
      repeat (60) @(posedge clock);

      $display("Covered %0d matrices (%0d singular, %0d saturated fields)",
               sent, sb.singular_seen, sb.saturated_seen);
      $display("under three sender/receiver stall mixes; %0d mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0 && sb.checked == sent) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
